// ===== rtl/core/dspg_pkg.sv =====
// Shared constants for the dual step/direction pulse generator.
package dspg_pkg;

  // Motor identifiers on the command stream.
  localparam logic [31:0] ID_MOTOR0 = 32'h0000_0100;
  localparam logic [31:0] ID_MOTOR1 = 32'h0000_0101;

  // Time scale constants.
  localparam int unsigned QUOT_W    = 20;
  localparam logic [QUOT_W-1:0] US_PER_S = 20'd1000000;
  localparam logic [9:0]  US_PER_MS = 10'd1000;
  localparam int unsigned PROD_W    = 26;

  // Command codes carried in the input tuser bit.
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_SPEED = 1'b1;

  // Configuration register indexes and reset values.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_W   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP = 2'd2;
  localparam logic [15:0] MAX_SPEED_RST = 16'd20000;
  localparam logic [7:0]  PULSE_W_RST   = 8'd2;
  localparam logic [7:0]  DIR_SETUP_RST = 8'd10;

endpackage

// ===== rtl/core/dual_stepper_pulse_generator_top.sv =====
// Dual stepper pulse generator: command decode, shared time unit and divider.
//
//  Channel     | Direction | Word contents
//  s_axis      | in        | tuser: command; tdata: motor_id, speed, timeout
//  m_axis      | out       | tuser: accepted; tdata: read_speed, steps, dirs, lamps, safe
//  cfg         | in        | write enable, register index, write data
//
// A tick word takes one time increment, then one to four steps per motor through
// the shared 64-bit adder and comparator.
// A set-speed word runs the 20-step restoring divider that forms 1000000 / speed.
// An unknown id or a stop goes from the magnitude check straight to the result.
// The block takes one word at a time; a finished word waits until the output
// register is free, and input is taken again in the cycle after it is loaded.
// Reset clears time and both motor channels and loads the configuration defaults.
module dual_stepper_pulse_generator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // tdata: motor_id[31:0], speed[63:32], timeout[79:64]
  input  logic [79:0]                    s_axis_tdata_i,
  // tuser: command[0]
  input  logic                           s_axis_tuser_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: read_speed[16:0], step_lines[18:17], dir_lines[20:19],
  //        busy_lamps[22:21], safe_stopped[24:23], zero fill[31:25]
  output logic [31:0]                    m_axis_tdata_o,
  // tuser: accepted[0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  input  logic                           cfg_we_i,
  input  logic [dspg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                    cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TINC,
    ST_TWD,
    ST_TFALL,
    ST_TRISE,
    ST_TNEXT,
    ST_SMAG,
    ST_SDIV,
    ST_SSET,
    ST_SDL,
    ST_FIN
  } state_e;

  localparam int unsigned QW = dspg_pkg::QUOT_W;
  localparam int unsigned PW = dspg_pkg::PROD_W;

  // Control and channel state.
  state_e        state_q, state_d;
  logic          ch_q, ch_d;
  logic          known_q, known_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [15:0]   max_speed_q;
  logic [7:0]    pulse_w_q;
  logic [7:0]    dir_setup_q;
  logic [63:0]   time_q, time_d;
  logic [16:0]   spd_q [2];
  logic [16:0]   spd_d [2];
  logic [15:0]   rate_q [2];
  logic [15:0]   rate_d [2];
  logic [QW-1:0] intv_q [2];
  logic [QW-1:0] intv_d [2];
  logic [63:0]   nrise_q [2];
  logic [63:0]   nrise_d [2];
  logic [63:0]   fall_q [2];
  logic [63:0]   fall_d [2];
  logic [63:0]   dl_q [2];
  logic [63:0]   dl_d [2];
  logic [1:0]    armed_q, armed_d;
  logic [1:0]    step_q, step_d;
  logic [1:0]    dir_q, dir_d;
  logic [1:0]    lamp_q, lamp_d;
  logic [1:0]    safe_q, safe_d;
  logic          acc_q, acc_d;
  logic [16:0]   rspd_q, rspd_d;
  logic          m_valid_q, m_valid_d;

  // Payload registers.
  logic [31:0]   speed_q, speed_d;
  logic [15:0]   tmo_q, tmo_d;
  logic [15:0]   mag_q, mag_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [15:0]   rem_q, rem_d;
  logic [QW-1:0] quot_q, quot_d;
  logic [24:0]   out_q, out_d;
  logic          out_acc_q, out_acc_d;

  // Shared time unit: one adder and one comparator against the current time.
  logic [63:0]   add_opnd;
  logic [63:0]   sum;
  logic [63:0]   cmp_opnd;
  logic          ge;

  // Magnitude and divider step.
  logic [31:0]   mag32;
  logic [15:0]   mag_sat;
  logic [16:0]   trial;
  logic          qbit;

  logic          s_fire;
  logic          out_free;

  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;

  // Operand selection for the shared adder and comparator.
  always_comb begin
    add_opnd = 64'd1;
    cmp_opnd = nrise_q[ch_q];
    case (state_q)
      ST_TRISE: add_opnd = {56'd0, pulse_w_q};
      ST_TNEXT: add_opnd = {{(64-QW){1'b0}}, intv_q[ch_q]};
      ST_SSET:  add_opnd = {56'd0, dir_setup_q};
      ST_SDL:   add_opnd = {{(64-PW){1'b0}}, prod_q};
      default:  add_opnd = 64'd1;
    endcase
    case (state_q)
      ST_TWD:   cmp_opnd = dl_q[ch_q];
      ST_TFALL: cmp_opnd = fall_q[ch_q];
      default:  cmp_opnd = nrise_q[ch_q];
    endcase
  end

  assign sum = time_q + add_opnd;
  assign ge  = time_q >= cmp_opnd;

  // Requested magnitude, saturated to the maximum rate.
  assign mag32   = speed_q[31] ? (32'd0 - speed_q) : speed_q;
  assign mag_sat = (mag32 > {16'd0, max_speed_q}) ? max_speed_q : mag32[15:0];

  // One restoring division step on the constant dividend.
  assign trial = {rem_q, dspg_pkg::US_PER_S[cnt_q]};
  assign qbit  = trial >= {1'b0, mag_q};

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    ch_d      = ch_q;
    known_d   = known_q;
    cnt_d     = cnt_q;
    time_d    = time_q;
    spd_d     = spd_q;
    rate_d    = rate_q;
    intv_d    = intv_q;
    nrise_d   = nrise_q;
    fall_d    = fall_q;
    dl_d      = dl_q;
    armed_d   = armed_q;
    step_d    = step_q;
    dir_d     = dir_q;
    lamp_d    = lamp_q;
    safe_d    = safe_q;
    acc_d     = acc_q;
    rspd_d    = rspd_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    speed_d   = speed_q;
    tmo_d     = tmo_q;
    mag_d     = mag_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    quot_d    = quot_q;
    out_d     = out_q;
    out_acc_d = out_acc_q;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          speed_d = s_axis_tdata_i[63:32];
          tmo_d   = s_axis_tdata_i[79:64];
          known_d = (s_axis_tdata_i[31:0] == dspg_pkg::ID_MOTOR0) ||
                    (s_axis_tdata_i[31:0] == dspg_pkg::ID_MOTOR1);
          ch_d    = s_axis_tdata_i[31:0] == dspg_pkg::ID_MOTOR1;
          safe_d  = 2'b00;
          acc_d   = 1'b0;
          rspd_d  = 17'd0;
          if (s_axis_tuser_i == dspg_pkg::CMD_TICK) begin
            state_d = ST_TINC;
          end else begin
            state_d = ST_SMAG;
          end
        end
      end

      // Tick: advance time, then serve motor 0 and motor 1.
      ST_TINC: begin
        time_d  = sum;
        ch_d    = 1'b0;
        state_d = ST_TWD;
      end

      ST_TWD: begin
        if (armed_q[ch_q] && ge) begin
          step_d[ch_q]  = 1'b0;
          lamp_d[ch_q]  = 1'b0;
          spd_d[ch_q]   = 17'd0;
          rate_d[ch_q]  = 16'd0;
          armed_d[ch_q] = 1'b0;
          dl_d[ch_q]    = 64'd0;
          safe_d[ch_q]  = 1'b1;
          ch_d          = 1'b1;
          state_d       = ch_q ? ST_FIN : ST_TWD;
        end else begin
          state_d = ST_TFALL;
        end
      end

      ST_TFALL: begin
        if (step_q[ch_q] && ge) begin
          step_d[ch_q] = 1'b0;
        end
        state_d = ST_TRISE;
      end

      ST_TRISE: begin
        if (rate_q[ch_q] == 16'd0 || step_q[ch_q] || !ge) begin
          ch_d    = 1'b1;
          state_d = ch_q ? ST_FIN : ST_TWD;
        end else begin
          step_d[ch_q] = 1'b1;
          fall_d[ch_q] = sum;
          state_d      = ST_TNEXT;
        end
      end

      ST_TNEXT: begin
        nrise_d[ch_q] = sum;
        ch_d          = 1'b1;
        state_d       = ch_q ? ST_FIN : ST_TWD;
      end

      // Set speed: skip an unknown id, saturate, then stop or start the divider.
      ST_SMAG: begin
        if (!known_q) begin
          state_d = ST_FIN;
        end else if (mag_sat == 16'd0) begin
          step_d[ch_q]  = 1'b0;
          lamp_d[ch_q]  = 1'b0;
          spd_d[ch_q]   = 17'd0;
          rate_d[ch_q]  = 16'd0;
          armed_d[ch_q] = 1'b0;
          dl_d[ch_q]    = 64'd0;
          acc_d         = 1'b1;
          state_d       = ST_FIN;
        end else begin
          mag_d   = mag_sat;
          prod_d  = PW'(tmo_q) * PW'(dspg_pkg::US_PER_MS);
          rem_d   = 16'd0;
          cnt_d   = 5'(QW - 1);
          state_d = ST_SDIV;
        end
      end

      ST_SDIV: begin
        rem_d  = qbit ? 16'(trial - {1'b0, mag_q}) : trial[15:0];
        quot_d = {quot_q[QW-2:0], qbit};
        cnt_d  = cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          state_d = ST_SSET;
        end
      end

      ST_SSET: begin
        step_d[ch_q]  = 1'b0;
        dir_d[ch_q]   = !speed_q[31];
        lamp_d[ch_q]  = 1'b1;
        spd_d[ch_q]   = speed_q[31] ? (17'd0 - {1'b0, mag_q}) : {1'b0, mag_q};
        rspd_d        = speed_q[31] ? (17'd0 - {1'b0, mag_q}) : {1'b0, mag_q};
        rate_d[ch_q]  = mag_q;
        intv_d[ch_q]  = quot_q;
        nrise_d[ch_q] = sum;
        acc_d         = 1'b1;
        state_d       = ST_SDL;
      end

      ST_SDL: begin
        armed_d[ch_q] = tmo_q != 16'd0;
        dl_d[ch_q]    = (tmo_q != 16'd0) ? sum : 64'd0;
        state_d       = ST_FIN;
      end

      // Hand the result word to the output register.
      ST_FIN: begin
        if (out_free) begin
          out_d     = {safe_q, lamp_q, dir_q, step_q, rspd_q};
          out_acc_d = acc_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State, channel and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= 1'b0;
      known_q     <= 1'b0;
      cnt_q       <= 5'd0;
      time_q      <= 64'd0;
      spd_q       <= '{default: '0};
      rate_q      <= '{default: '0};
      intv_q      <= '{default: '0};
      nrise_q     <= '{default: '0};
      fall_q      <= '{default: '0};
      dl_q        <= '{default: '0};
      armed_q     <= 2'b00;
      step_q      <= 2'b00;
      dir_q       <= 2'b00;
      lamp_q      <= 2'b00;
      safe_q      <= 2'b00;
      acc_q       <= 1'b0;
      rspd_q      <= 17'd0;
      m_valid_q   <= 1'b0;
      max_speed_q <= dspg_pkg::MAX_SPEED_RST;
      pulse_w_q   <= dspg_pkg::PULSE_W_RST;
      dir_setup_q <= dspg_pkg::DIR_SETUP_RST;
    end else begin
      state_q   <= state_d;
      ch_q      <= ch_d;
      known_q   <= known_d;
      cnt_q     <= cnt_d;
      time_q    <= time_d;
      spd_q     <= spd_d;
      rate_q    <= rate_d;
      intv_q    <= intv_d;
      nrise_q   <= nrise_d;
      fall_q    <= fall_d;
      dl_q      <= dl_d;
      armed_q   <= armed_d;
      step_q    <= step_d;
      dir_q     <= dir_d;
      lamp_q    <= lamp_d;
      safe_q    <= safe_d;
      acc_q     <= acc_d;
      rspd_q    <= rspd_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          dspg_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i;
          dspg_pkg::CFG_PULSE_W:   pulse_w_q   <= cfg_wdata_i[7:0];
          dspg_pkg::CFG_DIR_SETUP: dir_setup_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

  // Operand and result payload registers.
  always_ff @(posedge clk_i) begin
    speed_q   <= speed_d;
    tmo_q     <= tmo_d;
    mag_q     <= mag_d;
    prod_q    <= prod_d;
    rem_q     <= rem_d;
    quot_q    <= quot_d;
    out_q     <= out_d;
    out_acc_q <= out_acc_d;
  end

  assign s_axis_tready_o = state_q == ST_IDLE;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = out_acc_q;
  assign m_axis_tdata_o  = {7'd0, out_q};

`ifndef SYNTH
  // A set-speed result never reports a watchdog stop.
  a_no_safe_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[24:23] == 2'b00))
    else $error("safe stop reported on a set-speed word");

  // An unknown id or a tick reports zero speed.
  a_rspd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o[16:0] == 17'd0))
    else $error("speed reported without an accepted command");

  // A step line is only high while the busy lamp is lit.
  a_step_needs_lamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tdata_o[18:17] & ~m_axis_tdata_o[22:21]) == 2'b00))
    else $error("step line high on an idle motor");

  // A running motor always has a nonzero step interval.
  a_intv_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_q[0] == 16'd0 || intv_q[0] != '0) && (rate_q[1] == 16'd0 || intv_q[1] != '0))
    else $error("running motor with zero interval");

  // The block takes one word at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input taken while a word is in progress");
`endif

endmodule

// ===== test/dual_stepper_pulse_generator_top_tb.sv =====
// Self-checking testbench for the dual step/direction pulse generator top level.
module dual_stepper_pulse_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int NUM_SETTINGS = 8;
  localparam int BLOCK_WORDS = 20;

  // One input word as the sender sees it.
  typedef struct packed {
    logic        cmd;
    logic [31:0] id;
    logic [31:0] speed;
    logic [15:0] tmo;
  } cmd_word_t;

  // One result word, split into its fields.
  typedef struct packed {
    logic        accepted;
    logic [16:0] speed;
    logic [1:0]  steps;
    logic [1:0]  dirs;
    logic [1:0]  lamps;
    logic [1:0]  safe;
  } status_t;

  // Per-motor channel state kept by the predictor.
  typedef struct packed {
    logic [16:0] speed;
    logic [15:0] rate;
    logic [19:0] interval;
    logic [63:0] next_rise;
    logic [63:0] fall_at;
    logic [63:0] deadline;
    logic        armed;
    logic        step;
    logic        dir;
    logic        lamp;
  } motor_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [79:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [dspg_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  dual_stepper_pulse_generator_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // Register settings walked through between blocks, extremes included.
  logic [15:0] max_speed_tab [NUM_SETTINGS] =
    '{16'd65535, 16'd20000, 16'd1000, 16'd0, 16'd40000, 16'd65535, 16'd5000, 16'd1};
  logic [7:0] pulse_w_tab [NUM_SETTINGS] =
    '{8'd20, 8'd2, 8'd0, 8'd255, 8'd1, 8'd255, 8'd7, 8'd3};
  logic [7:0] dir_setup_tab [NUM_SETTINGS] =
    '{8'd0, 8'd10, 8'd1, 8'd255, 8'd5, 8'd0, 8'd3, 8'd2};

  // Predictor state and configuration copy.
  logic [63:0] clock_us = '0;
  motor_t motors [2];
  logic [15:0] max_speed_cfg = dspg_pkg::MAX_SPEED_RST;
  logic [7:0] pulse_w_cfg = dspg_pkg::PULSE_W_RST;
  logic [7:0] dir_setup_cfg = dspg_pkg::DIR_SETUP_RST;

  cmd_word_t cmd_words [$];
  status_t pending_results [$];
  cmd_word_t held;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int queued_count = 0;
  int tick_count = 0;
  int speed_count = 0;
  int reject_count = 0;
  int safe_stop_count = 0;
  int rise_count = 0;
  int checked_count = 0;
  int err_count = 0;
  int quiet_cycles = 0;

  // Clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog stop: clears the channel as a zero speed does.
  function automatic void halt_motor(int k);
    motors[k].step = 1'b0;
    motors[k].lamp = 1'b0;
    motors[k].speed = '0;
    motors[k].rate = '0;
    motors[k].armed = 1'b0;
    motors[k].deadline = '0;
  endfunction

  // Set-speed word on a known motor.
  function automatic void load_motor_rate(int k, logic [31:0] raw, logic [15:0] tmo);
    logic fwd;
    logic [31:0] mag32;
    logic [15:0] mag;
    fwd = !raw[31];
    mag32 = fwd ? raw : -raw;
    mag = (mag32 > {16'd0, max_speed_cfg}) ? max_speed_cfg : mag32[15:0];
    if (mag == 16'd0) begin
      halt_motor(k);
      return;
    end
    motors[k].step = 1'b0;
    motors[k].dir = fwd;
    motors[k].lamp = 1'b1;
    motors[k].speed = fwd ? {1'b0, mag} : -{1'b0, mag};
    motors[k].rate = mag;
    motors[k].interval = dspg_pkg::US_PER_S / mag;
    motors[k].next_rise = clock_us + 64'(dir_setup_cfg);
    motors[k].armed = (tmo != 16'd0);
    motors[k].deadline = (tmo != 16'd0) ?
                         clock_us + 64'(tmo) * 64'(dspg_pkg::US_PER_MS) : '0;
  endfunction

  // One microsecond of work on a channel; returns 1 on a watchdog stop.
  function automatic bit advance_motor(int k);
    if (motors[k].armed && clock_us >= motors[k].deadline) begin
      halt_motor(k);
      return 1'b1;
    end
    if (motors[k].step && clock_us >= motors[k].fall_at) motors[k].step = 1'b0;
    if (motors[k].rate == 16'd0 || motors[k].step || clock_us < motors[k].next_rise)
      return 1'b0;
    motors[k].step = 1'b1;
    motors[k].fall_at = clock_us + 64'(pulse_w_cfg);
    motors[k].next_rise = clock_us + 64'(motors[k].interval);
    rise_count++;
    return 1'b0;
  endfunction

  // Works out the status word that an accepted command word must produce.
  function automatic void predict_word(cmd_word_t w);
    status_t r;
    int k;
    r = '0;
    if (w.cmd == dspg_pkg::CMD_TICK) begin
      tick_count++;
      clock_us = clock_us + 64'd1;
      for (int i = 0; i < 2; i++) r.safe[i] = advance_motor(i);
      if (r.safe != 2'b00) safe_stop_count++;
    end else begin
      speed_count++;
      k = (w.id == dspg_pkg::ID_MOTOR0) ? 0 : (w.id == dspg_pkg::ID_MOTOR1) ? 1 : -1;
      if (k < 0) begin
        reject_count++;
      end else begin
        load_motor_rate(k, w.speed, w.tmo);
        r.accepted = 1'b1;
        r.speed = motors[k].speed;
      end
    end
    for (int i = 0; i < 2; i++) begin
      r.steps[i] = motors[i].step;
      r.dirs[i] = motors[i].dir;
      r.lamps[i] = motors[i].lamp;
    end
    pending_results.push_back(r);
  endfunction

  function automatic void check_field(string fname, logic [16:0] want, logic [16:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want, got);
      err_count++;
    end
  endfunction

  // Stimulus helpers.
  task automatic push_word(cmd_word_t w);
    cmd_words.push_back(w);
    queued_count++;
  endtask

  task automatic push_tick(logic [79:0] noise);
    cmd_word_t w;
    w.cmd = dspg_pkg::CMD_TICK;
    {w.tmo, w.speed, w.id} = noise;
    push_word(w);
  endtask

  task automatic push_speed(logic [31:0] id, logic [31:0] speed, logic [15:0] tmo);
    cmd_word_t w;
    w.cmd = dspg_pkg::CMD_SPEED;
    w.id = id;
    w.speed = speed;
    w.tmo = tmo;
    push_word(w);
  endtask

  function automatic logic [79:0] tick_noise();
    return 80'({$urandom, $urandom, $urandom});
  endfunction

  // Mostly the two real motors; the rest are near misses and random ids.
  function automatic logic [31:0] pick_id();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return dspg_pkg::ID_MOTOR0;
    if (sel <= 7) return dspg_pkg::ID_MOTOR1;
    if (sel == 8) return dspg_pkg::ID_MOTOR0 ^ (32'd1 << $urandom_range(1, 31));
    return $urandom;
  endfunction

  // Speeds cluster near the current limit so that steps actually happen.
  function automatic logic [31:0] pick_speed();
    logic [31:0] mag;
    int unsigned top;
    top = (max_speed_cfg == 16'd0) ? 100 : max_speed_cfg;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      3: mag = top + $urandom_range(1, 3);
      4, 5: mag = $urandom_range(1, top);
      default: mag = top - $urandom_range(0, top / 8);
    endcase
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(0, 7))
      0, 1, 2: return 16'd0;
      3: return 16'd1;
      4: return 16'hFFFF;
      default: return 16'($urandom_range(2, 65534));
    endcase
  endfunction

  // One or two speed words followed by a run of ticks, which may be empty.
  task automatic add_sequence();
    int n_words;
    int burst;
    n_words = $urandom_range(1, 2);
    repeat (n_words) push_speed(pick_id(), pick_speed(), pick_timeout());
    case ($urandom_range(0, 15))
      0: burst = 0;
      1: burst = $urandom_range(100, 300);
      default: burst = $urandom_range(1, 40);
    endcase
    repeat (burst) push_tick(tick_noise());
  endtask

  task automatic write_reg(logic [dspg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dspg_pkg::CFG_MAX_SPEED: max_speed_cfg = value;
      dspg_pkg::CFG_PULSE_W:   pulse_w_cfg = value[7:0];
      dspg_pkg::CFG_DIR_SETUP: dir_setup_cfg = value[7:0];
      default: ;
    endcase
  endtask

  // Waits until every word has gone in and every result has come back.
  task automatic wait_drained();
    while (cmd_words.size() != 0 || s_axis_tvalid_i || pending_results.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Sender: presents queued words, with random gaps.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) predict_word(held);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (cmd_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held = cmd_words.pop_front();
          s_axis_tdata_i <= {held.tmo, held.speed, held.id};
          s_axis_tuser_i <= held.cmd;
          s_axis_tvalid_i <= 1'b1;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_results.size() == 0) begin
          $error("result word 0x%0h arrived with no expectation waiting", m_axis_tdata_o);
          err_count++;
        end else begin
          status_t want;
          want = pending_results.pop_front();
          checked_count++;
          check_field("accepted", 17'(want.accepted), 17'(m_axis_tuser_o));
          check_field("read_speed", want.speed, m_axis_tdata_o[16:0]);
          check_field("step_lines", 17'(want.steps), 17'(m_axis_tdata_o[18:17]));
          check_field("dir_lines", 17'(want.dirs), 17'(m_axis_tdata_o[20:19]));
          check_field("busy_lamps", 17'(want.lamps), 17'(m_axis_tdata_o[22:21]));
          check_field("safe_stopped", 17'(want.safe), 17'(m_axis_tdata_o[24:23]));
        end
      end
      m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Ends the run if neither side moves a word for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int target;
    foreach (motors[k]) motors[k] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words under the reset settings: exact limit, saturation both ways,
    // unknown ids, extreme timeout, stops that keep the direction line.
    push_tick('0);
    push_speed(dspg_pkg::ID_MOTOR0, 32'd20000, 16'd0);
    push_speed(dspg_pkg::ID_MOTOR1, 32'hFFFF_FFFF, 16'hFFFF);
    push_speed(32'hFFFF_FFFF, 32'd5, 16'd3);
    push_speed(32'h0000_0000, 32'hFFFF_FFFB, 16'd0);
    push_tick({80{1'b1}});
    push_speed(dspg_pkg::ID_MOTOR0, 32'h7FFF_FFFF, 16'd1);
    push_speed(dspg_pkg::ID_MOTOR1, 32'h8000_0000, 16'd0);
    repeat (12) push_tick(tick_noise());
    push_speed(dspg_pkg::ID_MOTOR0, 32'd0, 16'd0);
    push_speed(dspg_pkg::ID_MOTOR1, 32'd0, 16'd7);
    push_tick(tick_noise());
    push_speed(dspg_pkg::ID_MOTOR1, 32'd20001, 16'd2);
    push_tick(tick_noise());
    wait_drained();

    // Random blocks, each under its own register setting and idle pattern.
    for (int blk = 0; blk < NUM_SETTINGS; blk++) begin
      case (blk % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 71; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 71; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      write_reg(dspg_pkg::CFG_MAX_SPEED, max_speed_tab[blk]);
      write_reg(dspg_pkg::CFG_PULSE_W, {8'd0, pulse_w_tab[blk]});
      write_reg(dspg_pkg::CFG_DIR_SETUP, {8'd0, dir_setup_tab[blk]});
      if (blk == 0) begin
        // Arm both watchdogs for one millisecond, a few ticks apart, and let them expire.
        push_speed(dspg_pkg::ID_MOTOR0, 32'd30000, 16'd1);
        repeat (5) push_tick(tick_noise());
        push_speed(dspg_pkg::ID_MOTOR1, -32'd50000, 16'd1);
        repeat (1010) push_tick(tick_noise());
      end
      target = queued_count + BLOCK_WORDS;
      while (queued_count < target) add_sequence();
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("Run covered %0d ticks and %0d speed words (%0d with unknown ids), %0d results checked.",
             tick_count, speed_count, reject_count, checked_count);
    $display("Predicted %0d step rises and %0d watchdog stop ticks over %0d register settings.",
             rise_count, safe_stop_count, NUM_SETTINGS + 1);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
